FILE: hw/rtl/bpa_pkg.sv
// bpa_pkg: shared constants and types for the bitmap page allocator
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAP_WORDS  = 1024;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned RESV_W      = 16;
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int unsigned BIT_W       = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned WIDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned TOTAL_PAGES = MAP_WORDS * WORD_BITS;

  // reserved page count after reset, and the init split it implies
  localparam int unsigned RESV_RESET  = 256;
  localparam int unsigned RESV_CLAMP  = (RESV_RESET > TOTAL_PAGES) ? TOTAL_PAGES : RESV_RESET;
  localparam int unsigned WHOLE_RESET = RESV_CLAMP / WORD_BITS;
  localparam int unsigned REST_RESET  = RESV_CLAMP % WORD_BITS;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WIDX_W-1:0]    widx_t;
  typedef logic [WIDX_W:0]      wcnt_t;
  typedef logic [BIT_W-1:0]     bidx_t;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_REINIT = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC_CHK,
    S_FREE_RD,
    S_FREE_WR
  } state_e;

  typedef struct packed {
    logic  we;
    widx_t waddr;
    word_t wdata;
    widx_t raddr;
  } ram_req_t;

endpackage

FILE: hw/rtl/bpa_map_ram.sv
// bpa_map_ram: page bitmap storage with one write port and one registered read port
`timescale 1ns / 1ps

module bpa_map_ram (
  input  logic              clk_i,
  input  bpa_pkg::ram_req_t req_i,
  output bpa_pkg::word_t    rdata_o
);

  bpa_pkg::word_t mem [bpa_pkg::MAP_WORDS];
  bpa_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bitmap_page_allocator.sv
// bitmap_page_allocator: first-fit page allocator over a bitmap in block ram
//
//   port group        dir  handshake           payload
//   command           in   start & !busy       func_i, page_address_i
//   result            out  done_o, one cycle   alloc_address_o, status_o
//   config            in   cfg_we_i            cfg_wdata_i (reserved pages)
//
// alloc reads map words from the lowest word that may hold a clear bit onward;
// the bitmap read port reads one word a cycle.
// free steps through accept, read and modify-write; unknown func and range
// errors are answered from accept. reinit sweeps the map one word a cycle.
// after reset the same sweep runs with busy high, no result.
// results cannot be stalled; done_o rises the cycle after the last work cycle.
`timescale 1ns / 1ps

module bitmap_page_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] page_address_i,
  output logic        done_o,
  output logic [31:0] alloc_address_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  bpa_pkg::state_e  state_q, state_d;
  bpa_pkg::widx_t   cnt_q, cnt_d;
  bpa_pkg::wcnt_t   whole_q, whole_d;
  bpa_pkg::bidx_t   rest_q, rest_d;
  logic             pend_q, pend_d;
  bpa_pkg::wcnt_t   hint_q, hint_d;
  bpa_pkg::widx_t   fw_q, fw_d;
  bpa_pkg::bidx_t   fb_q, fb_d;
  logic [bpa_pkg::RESV_W-1:0] resv_q;
  logic             done_q, done_d;
  logic [bpa_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [1:0]       status_q, status_d;

  bpa_pkg::ram_req_t ram_req;
  bpa_pkg::word_t    ram_rdata;

  logic             accept;
  logic             word_full;
  logic             last_word;
  logic             range_err;
  bpa_pkg::wcnt_t   hint_inc;
  bpa_pkg::word_t   clr_onehot;
  bpa_pkg::bidx_t   clr_bit;
  logic [bpa_pkg::ADDR_W-1:0] page_num;
  logic [bpa_pkg::ADDR_W-1:0] resv_clamp;
  bpa_pkg::word_t   part_mask;

  bpa_map_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign accept    = start && !busy;
  assign word_full = (ram_rdata == '1);
  assign hint_inc  = hint_q + 1'b1;
  assign last_word = (hint_inc == bpa_pkg::wcnt_t'(bpa_pkg::MAP_WORDS));
  assign page_num  = page_address_i >> bpa_pkg::PAGE_SHIFT;
  assign range_err = (page_num >= bpa_pkg::ADDR_W'(bpa_pkg::TOTAL_PAGES));
  assign resv_clamp = (bpa_pkg::ADDR_W'(resv_q) > bpa_pkg::ADDR_W'(bpa_pkg::TOTAL_PAGES)) ?
                      bpa_pkg::ADDR_W'(bpa_pkg::TOTAL_PAGES) : bpa_pkg::ADDR_W'(resv_q);
  assign part_mask = ~('1 << rest_q);

  // isolate the lowest clear bit and encode its position
  assign clr_onehot = ~ram_rdata & (ram_rdata + 1'b1);
  always_comb begin
    clr_bit = '0;
    for (int i = 0; i < bpa_pkg::WORD_BITS; i++) begin
      if (clr_onehot[i]) begin
        clr_bit = clr_bit | bpa_pkg::bidx_t'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpa_pkg::S_IDLE: begin
        if (accept) begin
          case (func_i)
            bpa_pkg::FUNC_ALLOC: begin
              if (hint_q != bpa_pkg::wcnt_t'(bpa_pkg::MAP_WORDS)) begin
                state_d = bpa_pkg::S_ALLOC_CHK;
              end
            end
            bpa_pkg::FUNC_FREE: begin
              if (!range_err) begin
                state_d = bpa_pkg::S_FREE_RD;
              end
            end
            bpa_pkg::FUNC_REINIT: state_d = bpa_pkg::S_INIT;
            default:              state_d = bpa_pkg::S_IDLE;
          endcase
        end
      end
      bpa_pkg::S_ALLOC_CHK: begin
        if (!word_full || last_word) begin
          state_d = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_FREE_RD: state_d = bpa_pkg::S_FREE_WR;
      bpa_pkg::S_FREE_WR: state_d = bpa_pkg::S_IDLE;
      bpa_pkg::S_INIT: begin
        if (cnt_q == bpa_pkg::widx_t'(bpa_pkg::MAP_WORDS - 1)) begin
          state_d = bpa_pkg::S_IDLE;
        end
      end
      default: state_d = bpa_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    cnt_d    = cnt_q;
    whole_d  = whole_q;
    rest_d   = rest_q;
    pend_d   = pend_q;
    hint_d   = hint_q;
    fw_d     = fw_q;
    fb_d     = fb_q;
    done_d   = 1'b0;
    addr_d   = addr_q;
    status_d = status_q;
    ram_req.we    = 1'b0;
    ram_req.waddr = hint_q[bpa_pkg::WIDX_W-1:0];
    ram_req.wdata = ram_rdata;
    ram_req.raddr = hint_q[bpa_pkg::WIDX_W-1:0];
    case (state_q)
      bpa_pkg::S_IDLE: begin
        if (accept) begin
          case (func_i)
            bpa_pkg::FUNC_ALLOC: begin
              if (hint_q == bpa_pkg::wcnt_t'(bpa_pkg::MAP_WORDS)) begin
                done_d   = 1'b1;
                addr_d   = '0;
                status_d = bpa_pkg::STAT_FULL;
              end
            end
            bpa_pkg::FUNC_FREE: begin
              if (range_err) begin
                done_d   = 1'b1;
                addr_d   = '0;
                status_d = bpa_pkg::STAT_RANGE;
              end else begin
                fw_d = page_num[bpa_pkg::BIT_W +: bpa_pkg::WIDX_W];
                fb_d = page_num[bpa_pkg::BIT_W-1:0];
              end
            end
            bpa_pkg::FUNC_REINIT: begin
              whole_d = resv_clamp[bpa_pkg::BIT_W +: bpa_pkg::WIDX_W+1];
              rest_d  = resv_clamp[bpa_pkg::BIT_W-1:0];
              cnt_d   = '0;
              pend_d  = 1'b1;
            end
            default: begin
              done_d   = 1'b1;
              addr_d   = '0;
              status_d = bpa_pkg::STAT_OK;
            end
          endcase
        end
      end
      bpa_pkg::S_ALLOC_CHK: begin
        if (word_full) begin
          // every word below the hint stays full, so first fit still holds
          hint_d        = hint_inc;
          ram_req.raddr = hint_inc[bpa_pkg::WIDX_W-1:0];
          if (last_word) begin
            done_d   = 1'b1;
            addr_d   = '0;
            status_d = bpa_pkg::STAT_FULL;
          end
        end else begin
          ram_req.we    = 1'b1;
          ram_req.wdata = ram_rdata | clr_onehot;
          done_d        = 1'b1;
          addr_d        = bpa_pkg::ADDR_W'({hint_q[bpa_pkg::WIDX_W-1:0], clr_bit})
                          << bpa_pkg::PAGE_SHIFT;
          status_d      = bpa_pkg::STAT_OK;
        end
      end
      bpa_pkg::S_FREE_RD: begin
        ram_req.raddr = fw_q;
      end
      bpa_pkg::S_FREE_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = fw_q;
        ram_req.wdata = ram_rdata & ~(bpa_pkg::word_t'(1) << fb_q);
        if ({1'b0, fw_q} < hint_q) begin
          hint_d = {1'b0, fw_q};
        end
        done_d   = 1'b1;
        addr_d   = '0;
        status_d = bpa_pkg::STAT_OK;
      end
      bpa_pkg::S_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_q;
        if ({1'b0, cnt_q} < whole_q) begin
          ram_req.wdata = '1;
        end else if ({1'b0, cnt_q} == whole_q) begin
          ram_req.wdata = part_mask;
        end else begin
          ram_req.wdata = '0;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == bpa_pkg::widx_t'(bpa_pkg::MAP_WORDS - 1)) begin
          hint_d = whole_q;
          if (pend_q) begin
            pend_d   = 1'b0;
            done_d   = 1'b1;
            addr_d   = '0;
            status_d = bpa_pkg::STAT_OK;
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bpa_pkg::S_INIT;
      cnt_q    <= '0;
      whole_q  <= bpa_pkg::wcnt_t'(bpa_pkg::WHOLE_RESET);
      rest_q   <= bpa_pkg::bidx_t'(bpa_pkg::REST_RESET);
      pend_q   <= 1'b0;
      hint_q   <= bpa_pkg::wcnt_t'(bpa_pkg::WHOLE_RESET);
      resv_q   <= bpa_pkg::RESV_W'(bpa_pkg::RESV_RESET);
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      whole_q  <= whole_d;
      rest_q   <= rest_d;
      pend_q   <= pend_d;
      hint_q   <= hint_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        resv_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fw_q     <= fw_d;
    fb_q     <= fb_d;
    addr_q   <= addr_d;
    status_q <= status_d;
  end

  assign busy            = (state_q != bpa_pkg::S_IDLE);
  assign done_o          = done_q;
  assign alloc_address_o = addr_q;
  assign status_o        = status_q;

endmodule

FILE: hw/rtl/bpa_checker.sv
// bpa_checker: port-level assertions for the bitmap page allocator, with bind
`timescale 1ns / 1ps

module bpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func_i,
  input logic [31:0] page_address_i,
  input logic        done_o,
  input logic [31:0] alloc_address_o,
  input logic [1:0]  status_o
);

  // a failing transaction never carries an address
  a_err_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != bpa_pkg::STAT_OK) |-> alloc_address_o == '0)
    else $error("error result with nonzero address");

  // allocated addresses are page aligned
  a_addr_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> alloc_address_o[bpa_pkg::PAGE_SHIFT-1:0] == '0)
    else $error("unaligned alloc address");

  // unknown func answers in the next cycle with ok
  a_unknown_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i == bpa_pkg::FUNC_NONE)
      |=> done_o && (status_o == bpa_pkg::STAT_OK) && !busy)
    else $error("unknown func not answered");

  // out of range free is flagged in the next cycle
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i == bpa_pkg::FUNC_FREE) &&
    ((page_address_i >> bpa_pkg::PAGE_SHIFT) >= 32'(bpa_pkg::TOTAL_PAGES))
      |=> done_o && (status_o == bpa_pkg::STAT_RANGE))
    else $error("range error not flagged");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
